/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Both sample on clk and are
// switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define TLEI_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define TLEI_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/tlei_pkg.sv */
package tlei_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_ABS    = 2'd0;
  localparam logic [1:0] CMD_REL    = 2'd1;
  localparam logic [1:0] CMD_TARGET = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_HOME_X         = 3'd0;
  localparam logic [2:0] REG_HOME_Z         = 3'd1;
  localparam logic [2:0] REG_REVERSE_START  = 3'd2;
  localparam logic [2:0] REG_BACK_AND_FORTH = 3'd3;
  localparam logic [2:0] REG_RUN_FOREVER    = 3'd4;
  localparam logic [2:0] REG_REPEAT_COUNT   = 3'd5;
  localparam logic [2:0] REG_DEFAULT_FRAMES = 3'd6;

  // The quotient of one axis is below the 17-bit span magnitude, so the
  // divider needs only that many restoring steps.
  localparam int QUOT_W    = 17;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [15:0]  point_a_x;
    logic signed [15:0]  point_a_z;
    logic signed [15:0]  point_b_x;
    logic signed [15:0]  point_b_z;
    logic [15:0]         frames;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0]  position_x;
    logic signed [15:0]  position_z;
    logic                running;
    logic [15:0]         frame_number;
    logic                moving_backward;
  } out_word_t;

  // Clamp a 17-bit signed sum to the 16-bit coordinate range.
  function automatic logic [15:0] sat16(input logic [16:0] v);
    logic [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'h8000 : 16'h7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* sv/tlei_chan.sv */
interface tlei_chan #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/two_axis_linear_easing_interpolator.sv */
// Two-axis move interpolator with repeat and back-and-forth passes.
// The item channel takes one command word: an absolute, relative or target
// move, which loads a new move, or a frame tick, which advances it. Every
// accepted word gives exactly one result word on the result channel with
// both coordinates (signed Q9.6), the running flag, the frame number and
// the direction. Both channels move a word when valid and ready are high.
// The block takes one word at a time: ready is high only while it is idle.
// A move word passes the span and done states before its result is raised;
// a tick at a pass end or on a one-frame pass passes the evaluate and done
// states, and a tick on an idle move goes straight to done. An interpolating
// tick runs multiply, divide and apply for each axis in turn: one 17x16
// multiplier and one 17-step restoring divider are shared by the two axes.
// The next word is taken only once the sequencer is back in idle.
// The result sits in an output register; a new word is taken while it
// waits, but the next result is held back until the receiver takes the
// previous one.
// Reset (rst, synchronous) clears the move, sets the registers to their
// defaults and places the current point at home. A write to home_x or
// home_z also moves the current point on that axis.
`include "assert_macros.svh"

module two_axis_linear_easing_interpolator (
  input  logic        clk,
  input  logic        rst,
  tlei_chan.sink      item,
  tlei_chan.source    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic signed [15:0] home_x, home_z;
  logic               reverse_start, back_and_forth, run_forever;
  logic [7:0]         repeat_count;
  logic [15:0]        default_frames;

  // Move state.
  logic signed [15:0] start_x, start_z, end_x, end_z, now_x, now_z;
  logic signed [16:0] span_x, span_z;
  logic [15:0]        frame_index, frame_total;
  logic               backward, endless;
  logic [9:0]         passes_left;

  // Sequencer and shared arithmetic unit.
  tlei_pkg::state_t   state, state_next;
  logic               axis;
  logic [15:0]        rem;
  logic [tlei_pkg::QUOT_W-1:0] qbits;
  logic [tlei_pkg::STEP_W-1:0] step;
  logic               neg;
  logic               run_r;

  // Output register.
  logic                 out_valid;
  tlei_pkg::out_word_t  out_data;

  logic        accept, cfg_write, out_free, run_now, tick_cmd;
  logic [2:0]  cfg_index;
  logic [16:0] idx_inc, rel_sum_x, rel_sum_z;
  logic [15:0] frames_eff, num, den;
  logic [9:0]  passes_load;
  logic signed [16:0] span_sel;
  logic [16:0] span_mag;
  logic [32:0] prod;
  logic [16:0] trial;
  logic [17:0] diff;
  logic        take;
  logic [15:0] base;
  logic [17:0] qext, axis_val;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = paddr[4:2];

  always_comb begin
    unique case (cfg_index)
      tlei_pkg::REG_HOME_X:         prdata = {{16{home_x[15]}}, home_x};
      tlei_pkg::REG_HOME_Z:         prdata = {{16{home_z[15]}}, home_z};
      tlei_pkg::REG_REVERSE_START:  prdata = {31'd0, reverse_start};
      tlei_pkg::REG_BACK_AND_FORTH: prdata = {31'd0, back_and_forth};
      tlei_pkg::REG_RUN_FOREVER:    prdata = {31'd0, run_forever};
      tlei_pkg::REG_REPEAT_COUNT:   prdata = {24'd0, repeat_count};
      tlei_pkg::REG_DEFAULT_FRAMES: prdata = {16'd0, default_frames};
      default:                      prdata = 32'd0;
    endcase
  end

  assign item.ready   = (state == tlei_pkg::ST_IDLE);
  assign accept       = item.valid & item.ready;
  assign tick_cmd     = (item.data.command == tlei_pkg::CMD_TICK);
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign out_free     = ~out_valid | result.ready;

  assign run_now   = (passes_left != 10'd0) | endless;
  assign idx_inc   = {1'b0, frame_index} + 17'd1;
  assign rel_sum_x = {now_x[15], now_x} + {item.data.point_a_x[15], item.data.point_a_x};
  assign rel_sum_z = {now_z[15], now_z} + {item.data.point_a_z[15], item.data.point_a_z};

  always_comb begin
    if (item.data.frames != 16'd0) begin
      frames_eff = item.data.frames;
    end else if (default_frames != 16'd0) begin
      frames_eff = default_frames;
    end else begin
      frames_eff = 16'd1;
    end
    if (run_forever) begin
      passes_load = 10'd0;
    end else if (back_and_forth) begin
      passes_load = {1'b0, repeat_count, 1'b0};
    end else begin
      passes_load = {2'b00, repeat_count};
    end
  end

  // Shared multiply and divide step: |span| * (i-1) / (n-1) on one axis.
  assign span_sel = axis ? span_z : span_x;
  assign span_mag = span_sel[16] ? 17'(-span_sel) : 17'(span_sel);
  assign num      = frame_index - 16'd1;
  assign den      = frame_total - 16'd1;
  assign prod     = {16'd0, span_mag} * {17'd0, num};
  assign trial    = {rem, qbits[tlei_pkg::QUOT_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, den};
  assign take     = ~diff[17];

  // Forward runs add the quotient to the start, backward runs take it off
  // the end; the sign of the span decides which way that goes.
  assign base     = backward ? (axis ? end_z : end_x) : (axis ? start_z : start_x);
  assign qext     = (backward ^ neg) ? 18'(-{1'b0, qbits}) : {1'b0, qbits};
  assign axis_val = {{2{base[15]}}, base} + qext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlei_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlei_pkg::ST_IDLE: begin
        if (accept) begin
          if (!tick_cmd) begin
            state_next = tlei_pkg::ST_SPAN;
          end else if (run_now) begin
            state_next = tlei_pkg::ST_EVAL;
          end else begin
            state_next = tlei_pkg::ST_DONE;
          end
        end
      end
      tlei_pkg::ST_SPAN: state_next = tlei_pkg::ST_DONE;
      tlei_pkg::ST_EVAL: begin
        if (frame_index == frame_total || frame_total == 16'd1) begin
          state_next = tlei_pkg::ST_DONE;
        end else begin
          state_next = tlei_pkg::ST_MUL;
        end
      end
      tlei_pkg::ST_MUL: state_next = tlei_pkg::ST_DIV;
      tlei_pkg::ST_DIV: begin
        if (step == tlei_pkg::LAST_STEP) begin
          state_next = tlei_pkg::ST_APPLY;
        end
      end
      tlei_pkg::ST_APPLY: state_next = axis ? tlei_pkg::ST_DONE : tlei_pkg::ST_MUL;
      tlei_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tlei_pkg::ST_IDLE;
        end
      end
      default: state_next = tlei_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_x         <= '0;
      home_z         <= '0;
      reverse_start  <= 1'b0;
      back_and_forth <= 1'b0;
      run_forever    <= 1'b0;
      repeat_count   <= 8'd1;
      default_frames <= 16'd50;
      start_x        <= '0;
      start_z        <= '0;
      end_x          <= '0;
      end_z          <= '0;
      span_x         <= '0;
      span_z         <= '0;
      now_x          <= '0;
      now_z          <= '0;
      frame_index    <= '0;
      frame_total    <= 16'd50;
      backward       <= 1'b0;
      endless        <= 1'b0;
      passes_left    <= '0;
      axis           <= 1'b0;
      run_r          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == tlei_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          tlei_pkg::REG_HOME_X: begin
            home_x <= pwdata[15:0];
            now_x  <= pwdata[15:0];
          end
          tlei_pkg::REG_HOME_Z: begin
            home_z <= pwdata[15:0];
            now_z  <= pwdata[15:0];
          end
          tlei_pkg::REG_REVERSE_START:  reverse_start  <= pwdata[0];
          tlei_pkg::REG_BACK_AND_FORTH: back_and_forth <= pwdata[0];
          tlei_pkg::REG_RUN_FOREVER:    run_forever    <= pwdata[0];
          tlei_pkg::REG_REPEAT_COUNT:   repeat_count   <= pwdata[7:0];
          tlei_pkg::REG_DEFAULT_FRAMES: default_frames <= pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state)
        tlei_pkg::ST_IDLE: begin
          if (accept) begin
            if (!tick_cmd) begin
              // Load a new move; the span follows in the next cycle.
              if (item.data.command == tlei_pkg::CMD_ABS) begin
                start_x <= item.data.point_a_x;
                start_z <= item.data.point_a_z;
                now_x   <= item.data.point_a_x;
                now_z   <= item.data.point_a_z;
                end_x   <= item.data.point_b_x;
                end_z   <= item.data.point_b_z;
              end else begin
                start_x <= now_x;
                start_z <= now_z;
                if (item.data.command == tlei_pkg::CMD_REL) begin
                  end_x <= tlei_pkg::sat16(rel_sum_x);
                  end_z <= tlei_pkg::sat16(rel_sum_z);
                end else begin
                  end_x <= item.data.point_a_x;
                  end_z <= item.data.point_a_z;
                end
              end
              frame_index <= '0;
              frame_total <= frames_eff;
              backward    <= reverse_start;
              endless     <= run_forever;
              passes_left <= passes_load;
            end else begin
              run_r <= run_now;
              if (run_now) begin
                if (idx_inc > {1'b0, frame_total}) begin
                  if (back_and_forth) begin
                    backward    <= ~backward;
                    frame_index <= 16'd2;
                  end else begin
                    frame_index <= 16'd1;
                  end
                end else begin
                  frame_index <= idx_inc[15:0];
                end
              end
            end
          end
        end
        tlei_pkg::ST_SPAN: begin
          span_x <= {end_x[15], end_x} - {start_x[15], start_x};
          span_z <= {end_z[15], end_z} - {start_z[15], start_z};
          run_r  <= run_now;
        end
        tlei_pkg::ST_EVAL: begin
          axis <= 1'b0;
          if (frame_index == frame_total || frame_total == 16'd1) begin
            // Pass end, or a one-frame pass whose divisor is zero.
            now_x <= backward ? start_x : end_x;
            now_z <= backward ? start_z : end_z;
            if (frame_index == frame_total && !endless && passes_left != 10'd0) begin
              passes_left <= passes_left - 10'd1;
            end
          end
        end
        tlei_pkg::ST_MUL: begin
          rem   <= prod[32:tlei_pkg::QUOT_W];
          qbits <= prod[tlei_pkg::QUOT_W-1:0];
          neg   <= span_sel[16];
          step  <= '0;
        end
        tlei_pkg::ST_DIV: begin
          rem   <= take ? diff[15:0] : trial[15:0];
          qbits <= {qbits[tlei_pkg::QUOT_W-2:0], take};
          step  <= step + 1'b1;
        end
        tlei_pkg::ST_APPLY: begin
          if (axis) begin
            now_z <= axis_val[15:0];
          end else begin
            now_x <= axis_val[15:0];
          end
          axis <= ~axis;
        end
        tlei_pkg::ST_DONE: begin
          if (out_free) begin
            out_data.position_x      <= now_x;
            out_data.position_z      <= now_z;
            out_data.running         <= run_r;
            out_data.frame_number    <= frame_index;
            out_data.moving_backward <= backward;
          end
        end
        default: ;
      endcase
    end
  end

  // An endless move keeps no pass budget.
  `TLEI_ASSERT_ALWAYS(a_endless_budget, !endless || passes_left == 10'd0,
                      "endless move with a nonzero pass budget")

  // Between words the frame index stays within the pass, save the restart
  // at frame two of a one-frame back-and-forth pass.
  `TLEI_ASSERT_IMPLY(a_index_range, state == tlei_pkg::ST_IDLE,
                     frame_index <= frame_total || frame_index == 16'd2,
                     "frame index beyond the frame total")

  // A result word is only raised by the final sequencer step.
  `TLEI_ASSERT_IMPLY(a_result_source, $rose(out_valid),
                     $past(state) == tlei_pkg::ST_DONE,
                     "result word raised outside the final step")

endmodule
